FILE: sv/hstr_pkg.sv
// shared types, widths and constants of the half-space triangle rasterizer
package hstr_pkg;

	localparam int SUBPIXEL_BITS = 5;
	localparam int COORD_W       = 16;
	localparam int EDGE_W        = 32;
	localparam int PIX_W         = 11;
	localparam int ADDR_W        = 20;
	localparam int FBW_W         = 11;
	localparam int COLOR_W       = 32;
	localparam int NUM_EDGES     = 3;

	localparam logic [FBW_W-1:0]   FB_WIDTH_RESET = FBW_W'(1024);
	localparam logic [COLOR_W-1:0] COLOR_WHITE    = 32'hffffffff;
	localparam logic [COLOR_W-1:0] COLOR_BLACK    = 32'hff000000;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// one sample step in subpixel units, one bit wider than a coordinate
	localparam logic signed [COORD_W:0] SAMPLE_STEP = (COORD_W+1)'(1 << SUBPIXEL_BITS);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;

	// input beat data, vertex_x0 in the lowest bits
	typedef struct packed {
		coord_t y2;
		coord_t x2;
		coord_t y1;
		coord_t x1;
		coord_t y0;
		coord_t x0;
	} vtx_data_t;

	// output beat data, pixel_x in the lowest bits
	typedef struct packed {
		logic [3:0]                 pad;
		logic                       culled;
		logic [COLOR_W-1:0]         pixel_color;
		logic                       covered;
		logic [ADDR_W-1:0]          fb_address;
		logic signed [PIX_W-1:0]    pixel_y;
		logic signed [PIX_W-1:0]    pixel_x;
	} res_data_t;

	// triangle setup handed from the setup pipeline to the traversal stage
	typedef struct packed {
		logic                      valid;
		logic                      is_load;
		logic                      cull;
		coord_t                    min_x;
		coord_t                    max_x;
		coord_t                    min_y;
		coord_t                    max_y;
		coord_t [NUM_EDGES-1:0]    step_x;
		coord_t [NUM_EDGES-1:0]    step_y;
		edge_t  [NUM_EDGES-1:0]    f0;
		edge_t  [NUM_EDGES-1:0]    psx;
		edge_t  [NUM_EDGES-1:0]    psy;
	} setup_t;

endpackage

FILE: sv/half_space_triangle_rasterizer_unit.sv
// top level of the half-space triangle rasterizer: traversal state and output stage
//
// Input beats arrive on s_axis. tuser selects the request: load a triangle
// (three signed 11.5 vertices in tdata) or tick (tdata ignored). Every input
// beat gives exactly one output beat on m_axis, in order. A load beat answers
// with tuser low and only the culled flag set or clear; each tick answers with
// the next bounding-box sample in raster order (tuser high, tlast on the final
// sample of the box), or an all-zero beat when no triangle is active.
// cfg_we / cfg_wdata set the framebuffer row length used for fb_address; write
// it only while no beat is in flight.
// From input beat to output beat a result passes an input register, two setup
// stages (cross products, then edge constants and corner products) and the
// traversal stage that updates the edge values and loads the output register.
// Throughput is one beat per cycle in both directions while m_axis does not stall.
// When m_axis stalls, one further result is caught in a skid register and the
// pipeline then holds, with s_axis_tready low, until the receiver takes a beat.
// Reset clears the triangle state, the pipeline and output valids, and sets
// the row length to 1024.
module half_space_triangle_rasterizer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hstr_pkg::FBW_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// vertex_x0, vertex_y0, vertex_x1, vertex_y1, vertex_x2, vertex_y2
	input  logic [95:0]                      s_axis_tdata,
	// req_type
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pixel_x, pixel_y, fb_address, covered, pixel_color, culled, zero pad
	output logic [79:0]                      m_axis_tdata,
	// pixel_valid
	output logic                             m_axis_tuser,
	// last_pixel
	output logic                             m_axis_tlast
);

	logic [hstr_pkg::FBW_W-1:0] fb_width_q;

	logic                       active_q;
	hstr_pkg::coord_t           step_x_q [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t           step_y_q [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t            row_start_q [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t            cur_q [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t           box_min_x_q, box_max_x_q, box_max_y_q;
	hstr_pkg::coord_t           cursor_x_q, cursor_y_q;

	logic                       adv;
	hstr_pkg::setup_t           st;
	logic                       exec;

	hstr_pkg::edge_t            f_c [hstr_pkg::NUM_EDGES];
	logic                       cov_c;
	logic signed [hstr_pkg::COORD_W-1:0] px_full, py_full;
	logic signed [hstr_pkg::PIX_W-1:0]   px_c, py_c;
	logic [hstr_pkg::ADDR_W-1:0]         addr_c;
	logic signed [hstr_pkg::COORD_W:0]   next_x_c, next_y_c;
	logic                       more_x_c, more_y_c;

	hstr_pkg::res_data_t        res_data_c;
	logic                       res_user_c, res_last_c;

	logic                       out_valid_q, skid_valid_q;
	hstr_pkg::res_data_t        out_data_q, skid_data_q;
	logic                       out_user_q, skid_user_q, out_last_q, skid_last_q;
	logic                       take;

	assign adv           = !skid_valid_q;
	assign s_axis_tready = adv;
	assign exec          = adv && st.valid;
	assign take          = out_valid_q && m_axis_tready;

	hstr_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_axis_tvalid),
		.in_type  (s_axis_tuser),
		.in_vtx   (hstr_pkg::vtx_data_t'(s_axis_tdata)),
		.st       (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q <= hstr_pkg::FB_WIDTH_RESET;
		end else if (cfg_we) begin
			fb_width_q <= cfg_wdata;
		end
	end

	// traversal: corner edge values, coverage, address and cursor stepping
	always_comb begin
		for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
			f_c[i] = st.f0[i] + (st.psx[i] >>> hstr_pkg::SUBPIXEL_BITS)
				+ (st.psy[i] >>> hstr_pkg::SUBPIXEL_BITS);
		end
		cov_c   = !(cur_q[0][hstr_pkg::EDGE_W-1] | cur_q[1][hstr_pkg::EDGE_W-1]
			| cur_q[2][hstr_pkg::EDGE_W-1]);
		px_full = cursor_x_q >>> hstr_pkg::SUBPIXEL_BITS;
		py_full = cursor_y_q >>> hstr_pkg::SUBPIXEL_BITS;
		px_c    = px_full[hstr_pkg::PIX_W-1:0];
		py_c    = py_full[hstr_pkg::PIX_W-1:0];
		addr_c  = hstr_pkg::ADDR_W'(hstr_pkg::ADDR_W'(py_c) * hstr_pkg::ADDR_W'(fb_width_q))
			+ hstr_pkg::ADDR_W'(px_c);
		next_x_c = hstr_pkg::SAMPLE_STEP + cursor_x_q;
		next_y_c = hstr_pkg::SAMPLE_STEP + cursor_y_q;
		more_x_c = next_x_c < box_max_x_q;
		more_y_c = next_y_c < box_max_y_q;

		res_data_c = '0;
		res_user_c = 1'b0;
		res_last_c = 1'b0;
		if (st.is_load) begin
			res_data_c.culled = st.cull;
		end else if (active_q) begin
			res_user_c             = 1'b1;
			res_data_c.pixel_x     = px_c;
			res_data_c.pixel_y     = py_c;
			res_data_c.fb_address  = addr_c;
			res_data_c.covered     = cov_c;
			res_data_c.pixel_color = cov_c ? hstr_pkg::COLOR_WHITE : hstr_pkg::COLOR_BLACK;
			res_last_c             = !more_x_c && !more_y_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			box_min_x_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
				step_x_q[i]    <= '0;
				step_y_q[i]    <= '0;
				row_start_q[i] <= '0;
				cur_q[i]       <= '0;
			end
		end else if (exec) begin
			if (st.is_load) begin
				active_q    <= !st.cull;
				box_min_x_q <= st.min_x;
				box_max_x_q <= st.max_x;
				box_max_y_q <= st.max_y;
				cursor_x_q  <= st.min_x;
				cursor_y_q  <= st.min_y;
				for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
					step_x_q[i]    <= st.step_x[i];
					step_y_q[i]    <= st.step_y[i];
					row_start_q[i] <= f_c[i];
					cur_q[i]       <= f_c[i];
				end
			end else if (active_q) begin
				if (more_x_c) begin
					cursor_x_q <= next_x_c[hstr_pkg::COORD_W-1:0];
					for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
						cur_q[i] <= cur_q[i] + hstr_pkg::EDGE_W'(step_x_q[i]);
					end
				end else if (more_y_c) begin
					cursor_x_q <= box_min_x_q;
					cursor_y_q <= next_y_c[hstr_pkg::COORD_W-1:0];
					for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
						row_start_q[i] <= row_start_q[i] + hstr_pkg::EDGE_W'(step_y_q[i]);
						cur_q[i]       <= row_start_q[i] + hstr_pkg::EDGE_W'(step_y_q[i]);
					end
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= exec;
		end else if (exec) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
				out_last_q <= skid_last_q;
			end
		end else if (!out_valid_q || take) begin
			if (exec) begin
				out_data_q <= res_data_c;
				out_user_q <= res_user_c;
				out_last_q <= res_last_c;
			end
		end else if (exec) begin
			skid_data_q <= res_data_c;
			skid_user_q <= res_user_c;
			skid_last_q <= res_last_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: sv/hstr_setup.sv
// triangle setup pipeline: bounding box, edge steps, cross products and cull test
module hstr_setup (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic                in_type,
	input  hstr_pkg::vtx_data_t in_vtx,
	output hstr_pkg::setup_t    st
);

	logic                   valid_s1;
	logic                   type_s1;
	hstr_pkg::vtx_data_t    vtx_s1;

	logic                   valid_s2;
	logic                   type_s2;
	hstr_pkg::coord_t       min_x_s2, max_x_s2, min_y_s2, max_y_s2;
	hstr_pkg::coord_t       step_x_s2 [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t       step_y_s2 [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t        pa_s2 [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t        pb_s2 [hstr_pkg::NUM_EDGES];

	hstr_pkg::setup_t       st_s3;

	hstr_pkg::coord_t       x [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t       y [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t       min_x_c, max_x_c, min_y_c, max_y_c;
	hstr_pkg::coord_t       step_x_c [hstr_pkg::NUM_EDGES];
	hstr_pkg::coord_t       step_y_c [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t        pa_c [hstr_pkg::NUM_EDGES];
	hstr_pkg::edge_t        pb_c [hstr_pkg::NUM_EDGES];

	hstr_pkg::setup_t       st_c;
	hstr_pkg::edge_t        delta_c;

	function automatic hstr_pkg::coord_t min3(hstr_pkg::coord_t a, hstr_pkg::coord_t b,
			hstr_pkg::coord_t c);
		hstr_pkg::coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic hstr_pkg::coord_t max3(hstr_pkg::coord_t a, hstr_pkg::coord_t b,
			hstr_pkg::coord_t c);
		hstr_pkg::coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// stage 1 to 2: box, steps and vertex cross products
	always_comb begin
		x[0] = vtx_s1.x0;
		y[0] = vtx_s1.y0;
		x[1] = vtx_s1.x1;
		y[1] = vtx_s1.y1;
		x[2] = vtx_s1.x2;
		y[2] = vtx_s1.y2;
		min_x_c = min3(x[0], x[1], x[2]);
		max_x_c = max3(x[0], x[1], x[2]);
		min_y_c = min3(y[0], y[1], y[2]);
		max_y_c = max3(y[0], y[1], y[2]);
		for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
			step_x_c[i] = y[i] - y[(i + 1) % hstr_pkg::NUM_EDGES];
			step_y_c[i] = x[(i + 1) % hstr_pkg::NUM_EDGES] - x[i];
			pa_c[i] = hstr_pkg::edge_t'(x[i])
				* hstr_pkg::edge_t'(y[(i + 1) % hstr_pkg::NUM_EDGES]);
			pb_c[i] = hstr_pkg::edge_t'(x[(i + 1) % hstr_pkg::NUM_EDGES])
				* hstr_pkg::edge_t'(y[i]);
		end
	end

	// stage 2 to 3: edge constants, area sign and corner products
	always_comb begin
		st_c = '0;
		st_c.valid   = valid_s2;
		st_c.is_load = (type_s2 == hstr_pkg::REQ_LOAD);
		st_c.min_x   = min_x_s2;
		st_c.max_x   = max_x_s2;
		st_c.min_y   = min_y_s2;
		st_c.max_y   = max_y_s2;
		delta_c = '0;
		for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
			st_c.step_x[i] = step_x_s2[i];
			st_c.step_y[i] = step_y_s2[i];
			st_c.f0[i]  = (pa_s2[i] >>> hstr_pkg::SUBPIXEL_BITS)
				- (pb_s2[i] >>> hstr_pkg::SUBPIXEL_BITS);
			st_c.psx[i] = hstr_pkg::edge_t'(step_x_s2[i]) * hstr_pkg::edge_t'(min_x_s2);
			st_c.psy[i] = hstr_pkg::edge_t'(step_y_s2[i]) * hstr_pkg::edge_t'(min_y_s2);
			delta_c = delta_c + $signed(st_c.f0[i]);
		end
		st_c.cull = (delta_c <= 0) || (min_x_s2 >= max_x_s2) || (min_y_s2 >= max_y_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_s3    <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			st_s3    <= st_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			type_s1  <= in_type;
			vtx_s1   <= in_vtx;
			type_s2  <= type_s1;
			min_x_s2 <= min_x_c;
			max_x_s2 <= max_x_c;
			min_y_s2 <= min_y_c;
			max_y_s2 <= max_y_c;
			for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
				step_x_s2[i] <= step_x_c[i];
				step_y_s2[i] <= step_y_c[i];
				pa_s2[i]     <= pa_c[i];
				pb_s2[i]     <= pb_c[i];
			end
		end
	end

	assign st = st_s3;

endmodule

FILE: sv/hstr_checker.sv
// port-level checks on the rasterizer output stream, bound to the top level
module hstr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	hstr_pkg::res_data_t res;

	assign res = hstr_pkg::res_data_t'(m_axis_tdata);

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// only a pixel beat closes a box
	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("tlast on a beat that carries no pixel");

	// a load or idle answer carries nothing but the cull flag
	a_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> res.pixel_x == '0 && res.pixel_y == '0
			&& res.fb_address == '0 && !res.covered && res.pixel_color == '0
			&& !m_axis_tlast)
		else $error("non-pixel beat carries pixel fields");

	// pixel colour follows coverage and a pixel is never culled
	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !res.culled
			&& ((res.covered && res.pixel_color == hstr_pkg::COLOR_WHITE)
			|| (!res.covered && res.pixel_color == hstr_pkg::COLOR_BLACK)))
		else $error("pixel colour does not match coverage");

endmodule

bind half_space_triangle_rasterizer_unit hstr_checker u_hstr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: tb/half_space_triangle_rasterizer_unit_tb.sv
// self-checking testbench for the half-space triangle rasterizer unit
`timescale 1ns / 1ps

module half_space_triangle_rasterizer_unit_tb;

	localparam int SAMPLE_PITCH = 1 << hstr_pkg::SUBPIXEL_BITS;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 300;

	typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

	typedef struct {
		logic        req;
		logic [95:0] data;
	} in_beat_t;

	typedef struct {
		hstr_pkg::res_data_t data;
		logic                pixel_valid;
		logic                last_pixel;
	} pixel_beat_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [hstr_pkg::FBW_W-1:0] cfg_wdata = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [95:0]                s_axis_tdata = '0;
	logic                       s_axis_tuser = 1'b0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [79:0]                m_axis_tdata;
	logic                       m_axis_tuser;
	logic                       m_axis_tlast;

	half_space_triangle_rasterizer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// rasteriser state mirrored on the testbench side
	logic [hstr_pkg::FBW_W-1:0]         row_pitch = hstr_pkg::FB_WIDTH_RESET;
	logic                               tri_active = 1'b0;
	logic signed [hstr_pkg::COORD_W-1:0] step_x [hstr_pkg::NUM_EDGES];
	logic signed [hstr_pkg::COORD_W-1:0] step_y [hstr_pkg::NUM_EDGES];
	logic [hstr_pkg::EDGE_W-1:0]        row_edge [hstr_pkg::NUM_EDGES];
	logic [hstr_pkg::EDGE_W-1:0]        cur_edge [hstr_pkg::NUM_EDGES];
	int                                 box_min_x = 0, box_max_x = 0, box_max_y = 0;
	int                                 cur_x = 0, cur_y = 0;

	in_beat_t    pending_beats[$];
	pixel_beat_t awaited_results[$];
	int          n_queued = 0, n_accepted = 0, n_results = 0, n_mismatch = 0;
	int          idle_cycles = 0;
	bit          beat_taken = 0;

	initial begin
		for (int i = 0; i < hstr_pkg::NUM_EDGES; i++) begin
			step_x[i] = '0;
			step_y[i] = '0;
			row_edge[i] = '0;
			cur_edge[i] = '0;
		end
	end

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int lo3(int a, int b, int c);
		int m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic int hi3(int a, int b, int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic pixel_beat_t rasterize_beat(logic req, logic [95:0] raw);
		pixel_beat_t         r;
		hstr_pkg::vtx_data_t v;
		int                  vx [3];
		int                  vy [3];
		longint              f0 [3];
		longint              delta, f, addr;
		int                  j, min_y, max_y, px, py, dx, dy;
		logic                cull, cov;
		r.data = '0;
		r.pixel_valid = 1'b0;
		r.last_pixel = 1'b0;
		v = raw;
		if (req == hstr_pkg::REQ_LOAD) begin
			vx[0] = v.x0; vy[0] = v.y0;
			vx[1] = v.x1; vy[1] = v.y1;
			vx[2] = v.x2; vy[2] = v.y2;
			box_min_x = lo3(vx[0], vx[1], vx[2]);
			box_max_x = hi3(vx[0], vx[1], vx[2]);
			min_y = lo3(vy[0], vy[1], vy[2]);
			max_y = hi3(vy[0], vy[1], vy[2]);
			box_max_y = max_y;
			delta = 0;
			for (int i = 0; i < 3; i++) begin
				j = (i + 1) % 3;
				dy = vy[i] - vy[j];
				dx = vx[j] - vx[i];
				step_x[i] = dy[15:0];
				step_y[i] = dx[15:0];
				f0[i] = ((longint'(vx[i]) * longint'(vy[j])) >>> hstr_pkg::SUBPIXEL_BITS)
					- ((longint'(vx[j]) * longint'(vy[i])) >>> hstr_pkg::SUBPIXEL_BITS);
				delta += f0[i];
			end
			for (int i = 0; i < 3; i++) begin
				f = f0[i]
					+ ((longint'(step_x[i]) * longint'(box_min_x)) >>> hstr_pkg::SUBPIXEL_BITS)
					+ ((longint'(step_y[i]) * longint'(min_y)) >>> hstr_pkg::SUBPIXEL_BITS);
				row_edge[i] = f[31:0];
				cur_edge[i] = f[31:0];
			end
			cur_x = box_min_x;
			cur_y = min_y;
			cull = (delta <= 0) || (box_min_x >= box_max_x) || (min_y >= max_y);
			tri_active = !cull;
			r.data.culled = cull;
			return r;
		end
		if (!tri_active)
			return r;
		cov = !(cur_edge[0][31] | cur_edge[1][31] | cur_edge[2][31]);
		px = cur_x >>> hstr_pkg::SUBPIXEL_BITS;
		py = cur_y >>> hstr_pkg::SUBPIXEL_BITS;
		addr = longint'(py) * longint'(row_pitch) + longint'(px);
		r.pixel_valid = 1'b1;
		r.data.pixel_x = px[10:0];
		r.data.pixel_y = py[10:0];
		r.data.fb_address = addr[19:0];
		r.data.covered = cov;
		r.data.pixel_color = cov ? hstr_pkg::COLOR_WHITE : hstr_pkg::COLOR_BLACK;
		if (cur_x + SAMPLE_PITCH < box_max_x) begin
			cur_x += SAMPLE_PITCH;
			for (int i = 0; i < 3; i++)
				cur_edge[i] = cur_edge[i] + hstr_pkg::EDGE_W'(step_x[i]);
		end else if (cur_y + SAMPLE_PITCH < box_max_y) begin
			cur_x = box_min_x;
			cur_y += SAMPLE_PITCH;
			for (int i = 0; i < 3; i++) begin
				row_edge[i] = row_edge[i] + hstr_pkg::EDGE_W'(step_y[i]);
				cur_edge[i] = row_edge[i];
			end
		end else begin
			r.last_pixel = 1'b1;
			tri_active = 1'b0;
		end
		return r;
	endfunction

	function automatic void push_beat(logic req, logic [95:0] d);
		in_beat_t b;
		b.req = req;
		b.data = d;
		pending_beats.push_back(b);
		n_queued++;
	endfunction

	// queues a load and returns the number of samples in its box
	function automatic int queue_load(int x0, int y0, int x1, int y1, int x2, int y2);
		hstr_pkg::vtx_data_t v;
		int                  mnx, mxx, mny, mxy;
		v.x0 = 16'(x0); v.y0 = 16'(y0);
		v.x1 = 16'(x1); v.y1 = 16'(y1);
		v.x2 = 16'(x2); v.y2 = 16'(y2);
		push_beat(hstr_pkg::REQ_LOAD, v);
		mnx = lo3(x0, x1, x2);
		mxx = hi3(x0, x1, x2);
		mny = lo3(y0, y1, y2);
		mxy = hi3(y0, y1, y2);
		if (mxx <= mnx || mxy <= mny)
			return 0;
		return ((mxx - mnx + SAMPLE_PITCH - 1) / SAMPLE_PITCH)
			* ((mxy - mny + SAMPLE_PITCH - 1) / SAMPLE_PITCH);
	endfunction

	function automatic void queue_ticks(int n);
		for (int i = 0; i < n; i++)
			push_beat(hstr_pkg::REQ_TICK, {$urandom, $urandom, $urandom});
	endfunction

	function automatic int rand_coord();
		int c;
		c = $urandom_range(0, 65535);
		return c - 32768;
	endfunction

	function automatic void queue_random(int n);
		int made, kind, span, bx, by, samples, ticks, area2, t;
		int x0, y0, x1, y1, x2, y2;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				span = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40)
					: $urandom_range(40, 260);
				if ($urandom_range(0, 9) == 0) begin
					bx = $urandom_range(0, 1) ? -32768 : 32767 - span;
					by = $urandom_range(0, 1) ? -32768 : 32767 - span;
				end else begin
					bx = $urandom_range(0, 65535 - span);
					by = $urandom_range(0, 65535 - span);
					bx -= 32768;
					by -= 32768;
				end
				x0 = bx + $urandom_range(0, span); y0 = by + $urandom_range(0, span);
				x1 = bx + $urandom_range(0, span); y1 = by + $urandom_range(0, span);
				x2 = bx + $urandom_range(0, span); y2 = by + $urandom_range(0, span);
				area2 = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
				if (area2 < 0 && $urandom_range(0, 9) != 0) begin
					t = x1; x1 = x2; x2 = t;
					t = y1; y1 = y2; y2 = t;
				end
				samples = queue_load(x0, y0, x1, y1, x2, y2);
				case ($urandom_range(0, 9))
					0: ticks = $urandom_range(0, samples);
					1: ticks = samples + $urandom_range(1, 3);
					default: ticks = samples;
				endcase
			end else if (kind < 87) begin
				void'(queue_load(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord()));
				ticks = $urandom_range(0, 4);
			end else begin
				ticks = $urandom_range(1, 4);
				made--;
			end
			queue_ticks(ticks);
			made += 1 + ticks;
		end
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (n_accepted != n_queued || awaited_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_row_pitch(logic [hstr_pkg::FBW_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		row_pitch = value;
	endtask

	// sender: bursts of beats with random gaps
	int burst_left = 1, gap_left = 0;
	in_beat_t next_beat;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || beat_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					next_beat = pending_beats.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_beat.data;
					s_axis_tuser <= next_beat.req;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
						if ($urandom_range(0, 19) == 0)
							gap_left = $urandom_range(10, 30);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			beat_taken = 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			awaited_results.push_back(rasterize_beat(s_axis_tuser, s_axis_tdata));
			beat_taken = 1;
			n_accepted++;
		end
	end

	// receiver: stall pattern plus occasional long hold-off
	rx_mode_t   rx_mode = RX_READY;
	int         rx_timer = 0, hold_left = 0, next_hold_at = 500;
	logic [15:0] rx_pattern = '1;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (n_results >= next_hold_at) begin
			hold_left = LONG_HOLD;
			next_hold_at += 900;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_timer == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_timer = $urandom_range(16, 96);
				rx_pattern = 16'($urandom);
			end
			rx_timer--;
			case (rx_mode)
				RX_READY:   m_axis_tready <= 1'b1;
				RX_LIGHT:   m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY:   m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					m_axis_tready <= rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
				end
			endcase
		end
	end

	// monitor and watchdog
	hstr_pkg::res_data_t got;
	pixel_beat_t         want;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			n_results++;
			if (awaited_results.size() == 0) begin
				if (n_mismatch < 10)
					$display("%0t: result beat with nothing outstanding", $realtime);
				n_mismatch++;
			end else begin
				want = awaited_results.pop_front();
				if (got.pixel_x !== want.data.pixel_x || got.pixel_y !== want.data.pixel_y
					|| got.fb_address !== want.data.fb_address
					|| got.covered !== want.data.covered
					|| got.pixel_color !== want.data.pixel_color
					|| got.culled !== want.data.culled || got.pad !== want.data.pad
					|| m_axis_tuser !== want.pixel_valid
					|| m_axis_tlast !== want.last_pixel) begin
					if (n_mismatch < 10)
						$display({"%0t: beat %0d mismatch, expected v=%b x=%0d y=%0d a=%h c=%b",
							" col=%h last=%b cull=%b pad=%h, got v=%b x=%0d y=%0d a=%h c=%b",
							" col=%h last=%b cull=%b pad=%h"}, $realtime, n_results,
							want.pixel_valid, want.data.pixel_x, want.data.pixel_y,
							want.data.fb_address, want.data.covered, want.data.pixel_color,
							want.last_pixel, want.data.culled, want.data.pad,
							m_axis_tuser, got.pixel_x, got.pixel_y, got.fb_address,
							got.covered, got.pixel_color, m_axis_tlast, got.culled, got.pad);
					n_mismatch++;
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL half_space_triangle_rasterizer_unit");
			$finish;
		end
	end

	logic [hstr_pkg::FBW_W-1:0] phase_pitch [5];

	initial begin
		phase_pitch[0] = 11'd1;
		phase_pitch[1] = 11'd2047;
		phase_pitch[2] = 11'd0;
		phase_pitch[3] = 11'd1024;
		phase_pitch[4] = hstr_pkg::FBW_W'($urandom_range(1, 1024));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle tick, extreme vertices, culling, replacement, range corners
		queue_ticks(1);
		void'(queue_load(-32768, -32768, -32768, -32768, -32768, -32768));
		queue_ticks(1);
		void'(queue_load(32767, 32767, 32767, 32767, 32767, 32767));
		queue_ticks(1);
		void'(queue_load(-40, -40, -40, 40, 40, -40));
		void'(queue_load(-40, -40, 40, -40, -40, 40));
		queue_ticks(2);
		queue_ticks(queue_load(-40, -40, 40, -40, -40, 40) + 1);
		queue_ticks(queue_load(32740, 32740, 32767, 32740, 32740, 32767));
		queue_ticks(queue_load(-32768, -32768, -32740, -32768, -32768, -32740));
		queue_random(300);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			write_row_pitch(phase_pitch[p]);
			queue_random(340);
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (n_mismatch == 0 && awaited_results.size() == 0)
			$display("PASS half_space_triangle_rasterizer_unit");
		else
			$display("FAIL half_space_triangle_rasterizer_unit");
		$finish;
	end

endmodule
